// ===== rtl/zero_sum_subarray_detector_defines.svh =====
// Assertion macros for the RTL of the zero-sum subarray detector.
// The macros expect a signal named clk, and ZSSD_ASSERT_RUN also rst_n, in the enclosing module.
`ifndef ZERO_SUM_SUBARRAY_DETECTOR_DEFINES_SVH
`define ZERO_SUM_SUBARRAY_DETECTOR_DEFINES_SVH

// Checked at every edge, reset included.
`define ZSSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while reset is released.
`define ZSSD_ASSERT_RUN(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/zssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zssd_pkg;

    localparam int MAX_ELEMENTS_DEF = 256;
    localparam int VALUE_BITS_DEF   = 16;
    localparam int EPOCH_BITS       = 4;

    localparam logic [EPOCH_BITS-1:0] EPOCH_FREE  = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_DONE
    } zssd_state_t;

endpackage

`default_nettype wire

// ===== rtl/zssd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface zssd_in_if #(
    parameter int VALUE_BITS = zssd_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface zssd_out_if;
    logic valid;
    logic ready;
    logic found;
    logic table_full;
    logic is_last;

    modport source (output valid, output found, output table_full, output is_last,
                    input ready);
    modport sink   (input valid, input found, input table_full, input is_last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/zssd_table.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zssd_table #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 29
) (
    input  wire logic              clk,
    input  wire logic              re,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/zero_sum_subarray_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Zero-sum subarray detector.
// Input channel din carries one signed value per word; last marks the final word of an array.
// Output channel dout returns one word per input word: found, table_full and is_last.
// found goes high once the prefix sum of the current array is zero or repeats an earlier sum,
// and it stays high until the array ends; is_last marks the word that carries the final answer.
// Prefix sums are kept in a one-port hash table with linear probing, at least twice as deep
// as the number of sums an array may store, so a lookup always ends at an empty slot.
// A word passes through these steps: accept, one table read per probe, result.
// A word whose sum is zero or whose array already found a match skips the table.
// The next word is accepted while a result still waits in the output register; a stalled
// receiver holds the result and stops the block only when the following result is ready.
// Table slots carry an array tag, so ending an array clears nothing in the table.
// After reset, and after every fifteenth array, a clearing pass writes every slot, one per
// cycle (2 * 2**clog2(MAX_ELEMENTS) slots, 512 by default), while din.ready stays low.
`include "zero_sum_subarray_detector_defines.svh"

module zero_sum_subarray_detector #(
    parameter int MAX_ELEMENTS = zssd_pkg::MAX_ELEMENTS_DEF,
    parameter int VALUE_BITS   = zssd_pkg::VALUE_BITS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    zssd_in_if.sink   din,
    zssd_out_if.source dout
);

    import zssd_pkg::*;

    localparam int SUM_BITS = VALUE_BITS + 9;
    localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);
    localparam int TIDX_W   = $clog2(MAX_ELEMENTS) + 1;
    localparam int ENTRY_W  = EPOCH_BITS + SUM_BITS;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_ELEMENTS);

    function automatic logic [TIDX_W-1:0] hash_idx(input logic [SUM_BITS-1:0] s);
        logic [TIDX_W-1:0] h;
        h = '0;
        for (int i = 0; i < SUM_BITS; i++)
        begin
            h[i % TIDX_W] = h[i % TIDX_W] ^ s[i];
        end
        return h;
    endfunction

    zssd_state_t state_reg, state_next;

    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  found_reg, found_next;
    logic                  full_reg, full_next;
    logic                  last_reg, last_next;
    logic [EPOCH_BITS-1:0] epoch_reg, epoch_next;
    logic [TIDX_W-1:0]     addr_reg, addr_next;

    logic out_valid_reg, out_valid_next;
    logic out_found_reg, out_found_next;
    logic out_full_reg, out_full_next;
    logic out_last_reg, out_last_next;

    logic                  mem_re;
    logic                  mem_we;
    logic [TIDX_W-1:0]     mem_addr;
    logic [ENTRY_W-1:0]    mem_wdata;
    logic [ENTRY_W-1:0]    mem_rdata;

    logic [SUM_BITS-1:0]   value_ext;
    logic [SUM_BITS-1:0]   new_sum;
    logic [TIDX_W-1:0]     new_idx;
    logic [TIDX_W-1:0]     addr_inc;
    logic [EPOCH_BITS-1:0] rd_epoch;
    logic [SUM_BITS-1:0]   rd_sum;
    logic                  out_load;

    zssd_table #(
        .ADDR_W (TIDX_W),
        .DATA_W (ENTRY_W)
    ) u_table (
        .clk   (clk),
        .re    (mem_re),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign value_ext = {{(SUM_BITS - VALUE_BITS){din.value[VALUE_BITS-1]}}, din.value};
    assign new_sum   = sum_reg + value_ext;
    assign new_idx   = hash_idx(new_sum);
    assign addr_inc  = addr_reg + TIDX_W'(1);
    assign rd_epoch  = mem_rdata[ENTRY_W-1:SUM_BITS];
    assign rd_sum    = mem_rdata[SUM_BITS-1:0];

    assign din.ready       = (state_reg == ST_IDLE);
    assign dout.valid      = out_valid_reg;
    assign dout.found      = out_found_reg;
    assign dout.table_full = out_full_reg;
    assign dout.is_last    = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sum_reg       <= '0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            last_reg      <= 1'b0;
            epoch_reg     <= EPOCH_FIRST;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            found_reg     <= found_next;
            full_reg      <= full_next;
            last_reg      <= last_next;
            epoch_reg     <= epoch_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_full_reg  <= out_full_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        last_next      = last_reg;
        epoch_next     = epoch_reg;
        addr_next      = addr_reg;
        out_found_next = out_found_reg;
        out_full_next  = out_full_reg;
        out_last_next  = out_last_reg;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_addr       = addr_reg;
        mem_wdata      = {epoch_reg, sum_reg};
        out_load       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = {EPOCH_FREE, {SUM_BITS{1'b0}}};
                addr_next = addr_inc;
                if (addr_reg == '1)
                begin
                    epoch_next = EPOCH_FIRST;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    sum_next  = new_sum;
                    last_next = din.last;
                    if (found_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (new_sum == '0)
                    begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_addr   = new_idx;
                        addr_next  = new_idx;
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE:
            begin
                if (rd_epoch == epoch_reg)
                begin
                    if (rd_sum == sum_reg)
                    begin
                        found_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_addr  = addr_inc;
                        addr_next = addr_inc;
                    end
                end
                else
                begin
                    if (count_reg < COUNT_MAX)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || dout.ready)
                begin
                    out_load       = 1'b1;
                    out_found_next = found_reg;
                    out_full_next  = full_reg;
                    out_last_next  = last_reg;
                    state_next     = ST_IDLE;
                    if (last_reg)
                    begin
                        sum_next   = '0;
                        count_next = '0;
                        found_next = 1'b0;
                        full_next  = 1'b0;
                        if (epoch_reg == EPOCH_LAST)
                        begin
                            addr_next  = '0;
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EPOCH_BITS'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                addr_next  = '0;
            end
        endcase

        out_valid_next = out_load || (out_valid_reg && !dout.ready);
    end

    `ZSSD_ASSERT_ALWAYS(a_port_single, !(mem_re && mem_we), "table read and write collide")
    `ZSSD_ASSERT_RUN(a_count_bound, count_reg <= COUNT_MAX, "entry count above capacity")
    `ZSSD_ASSERT_RUN(a_full_only_at_cap, full_reg |-> (count_reg == COUNT_MAX), "full below cap")
    `ZSSD_ASSERT_RUN(a_end_clears, (out_load && last_reg) |=> (sum_reg == '0 && count_reg == '0 && !found_reg && !full_reg), "array end did not clear state")
    `ZSSD_ASSERT_RUN(a_found_sticky, (found_reg && !(out_load && last_reg)) |=> found_reg, "found dropped inside an array")

endmodule

`default_nettype wire
